// ===== rtl/mono_framebuffer_draw_engine_unit_macros.svh =====
// Assertion helpers for the draw engine; clock and reset are the block's own.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define MFDE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MFDE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mfde_pkg.sv =====
package mfde_pkg;

   localparam int DEF_COLUMNS = 128;
   localparam int DEF_PAGES   = 8;

   // command codes carried in req_tuser
   localparam logic [2:0] KIND_POINT   = 3'd0;
   localparam logic [2:0] KIND_FILL    = 3'd1;
   localparam logic [2:0] KIND_OUTLINE = 3'd2;
   localparam logic [2:0] KIND_CLEAR   = 3'd3;
   localparam logic [2:0] KIND_READ    = 3'd4;

   // which region the datapath loads for the next scan
   typedef enum logic [2:0] {
      REG_POINT,
      REG_FILL,
      REG_LEFT,
      REG_RIGHT,
      REG_TOP,
      REG_BOTTOM,
      REG_CLEAR,
      REG_ALL
   } region_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_CAPTURE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic           accept;
      region_sel_type sel;
      logic           load;
      logic           step;
      logic           rd_capture;
      logic           reject;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       region_ok;
      logic       read_ok;
      logic       scan_last;
   } dp_status_type;

endpackage

// ===== rtl/mfde_ctrl.sv =====
module mfde_ctrl
   import mfde_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type      state_ff, state_in;
   region_sel_type sel_ff, sel_in;

   // after reset the whole store is wiped before the first word is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         sel_ff   <= REG_ALL;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_LOAD;
            case (status.kind)
               KIND_POINT:   sel_in = REG_POINT;
               KIND_FILL:    sel_in = REG_FILL;
               KIND_OUTLINE: sel_in = REG_LEFT;
               KIND_CLEAR:   sel_in = REG_CLEAR;
               KIND_READ:    state_in = ST_RD_ISSUE;
               default:      state_in = ST_RESP;
            endcase
         end
         ST_LOAD, ST_DRAIN: begin
            if (state_ff == ST_LOAD && status.region_ok) begin
               state_in = ST_SCAN;
            end else begin
               // part finished or rejected: move to the next outline edge or finish
               state_in = ST_LOAD;
               case (sel_ff)
                  REG_LEFT:  sel_in = REG_RIGHT;
                  REG_RIGHT: sel_in = REG_TOP;
                  REG_TOP:   sel_in = REG_BOTTOM;
                  REG_ALL:   state_in = ST_IDLE;
                  default:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_RD_ISSUE:   state_in = ST_RD_CAPTURE;
         ST_RD_CAPTURE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd.accept     = 1'b0;
      cmd.sel        = sel_ff;
      cmd.load       = 1'b0;
      cmd.step       = 1'b0;
      cmd.rd_capture = 1'b0;
      cmd.reject     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_POINT, KIND_FILL, KIND_OUTLINE, KIND_CLEAR, KIND_READ: begin
                  cmd.reject = 1'b0;
               end
               default: cmd.reject = 1'b1;
            endcase
         end
         ST_LOAD: begin
            cmd.load   = status.region_ok;
            cmd.reject = !status.region_ok;
         end
         ST_SCAN:       cmd.step = 1'b1;
         ST_DRAIN:      cmd.step = 1'b0;
         ST_RD_ISSUE:   cmd.reject = !status.read_ok;
         ST_RD_CAPTURE: cmd.rd_capture = status.read_ok;
         ST_RESP:       rsp_tvalid = 1'b1;
         default:       cmd.step = 1'b0;
      endcase
   end

endmodule

// ===== rtl/mfde_datapath.sv =====
module mfde_datapath
   import mfde_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [47:0]   req_tdata,
   input  logic [2:0]    req_tuser,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic [7:0]    rsp_tdata,
   output logic [0:0]    rsp_tuser
);

   localparam int XW    = $clog2(COLUMNS);
   localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int AW    = XW + PGW;
   localparam int DEPTH = 1 << AW;
   localparam logic [7:0] X_MAX = 8'(COLUMNS - 1);
   localparam logic [7:0] Y_MAX = 8'(PAGES * 8 - 1);

   // latched request
   logic [2:0] kind_ff;
   logic [7:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic       on_req_ff;
   logic [2:0] page_ff;
   logic [6:0] col_ff;

   // scan region and cursor
   logic [7:0]     x_hi_ff, y_lo_ff, y_hi_ff;
   logic           on_ff;
   logic [7:0]     x_cur_ff;
   logic [PGW-1:0] p_cur_ff;
   logic [PGW-1:0] p_lo, p_hi;
   logic [2:0]     bit_lo, bit_hi;
   logic [7:0]     mask;

   // write stage of the read-modify-write
   logic          wr_en_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [7:0]    wr_mask_ff;
   logic          wr_on_ff;
   logic [7:0]    wr_data;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] scan_addr, read_addr, rd_addr;

   logic [7:0] rsp_byte_ff;
   logic       reject_ff;

   // region selection
   logic [7:0] xa, ya, xb, yb, xl, xh, yl, yh;
   logic       page_ok, sel_on;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_tuser;
         x1_ff     <= req_tdata[7:0];
         y1_ff     <= req_tdata[15:8];
         x2_ff     <= req_tdata[23:16];
         y2_ff     <= req_tdata[31:24];
         on_req_ff <= req_tdata[32];
         page_ff   <= req_tdata[35:33];
         col_ff    <= req_tdata[42:36];
      end
   end

   assign page_ok = 5'(page_ff) < 5'(PAGES);

   always_comb begin
      xa     = x1_ff;
      ya     = y1_ff;
      xb     = x1_ff;
      yb     = y1_ff;
      sel_on = on_req_ff;
      case (cmd.sel)
         REG_POINT: begin
            xb = x1_ff;
            yb = y1_ff;
         end
         REG_FILL: begin
            xb = x2_ff;
            yb = y2_ff;
         end
         REG_LEFT: begin
            yb = y2_ff;
         end
         REG_RIGHT: begin
            xa = x2_ff;
            xb = x2_ff;
            yb = y2_ff;
         end
         REG_TOP: begin
            xb = x2_ff;
         end
         REG_BOTTOM: begin
            ya = y2_ff;
            xb = x2_ff;
            yb = y2_ff;
         end
         REG_CLEAR: begin
            xa     = 8'd0;
            ya     = {2'b00, page_ff, 3'b000};
            xb     = X_MAX;
            yb     = Y_MAX;
            sel_on = 1'b0;
         end
         REG_ALL: begin
            xa     = 8'd0;
            ya     = 8'd0;
            xb     = X_MAX;
            yb     = Y_MAX;
            sel_on = 1'b0;
         end
         default: sel_on = 1'b0;
      endcase
      xl = (xa < xb) ? xa : xb;
      xh = (xa < xb) ? xb : xa;
      yl = (ya < yb) ? ya : yb;
      yh = (ya < yb) ? yb : ya;
   end

   always_comb begin
      status.kind      = kind_ff;
      status.read_ok   = (9'(col_ff) < 9'(COLUMNS)) && page_ok;
      status.scan_last = (x_cur_ff == x_hi_ff) && (p_cur_ff == p_hi);
      if (cmd.sel == REG_CLEAR) begin
         status.region_ok = page_ok;
      end else begin
         status.region_ok = (xh <= X_MAX) && (yh <= Y_MAX);
      end
   end

   assign p_lo   = PGW'(y_lo_ff[7:3]);
   assign p_hi   = PGW'(y_hi_ff[7:3]);
   assign bit_lo = (p_cur_ff == p_lo) ? y_lo_ff[2:0] : 3'd0;
   assign bit_hi = (p_cur_ff == p_hi) ? y_hi_ff[2:0] : 3'd7;
   assign mask   = (8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi));

   // column-major scan, pages inner
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_hi_ff  <= xh;
         y_lo_ff  <= yl;
         y_hi_ff  <= yh;
         on_ff    <= sel_on;
         x_cur_ff <= xl;
         p_cur_ff <= PGW'(yl[7:3]);
      end else if (cmd.step) begin
         if (p_cur_ff == p_hi) begin
            p_cur_ff <= p_lo;
            x_cur_ff <= x_cur_ff + 8'd1;
         end else begin
            p_cur_ff <= p_cur_ff + PGW'(1);
         end
      end
   end

   assign scan_addr = {x_cur_ff[XW-1:0], p_cur_ff};
   assign read_addr = {XW'(col_ff), PGW'(page_ff)};
   assign rd_addr   = cmd.step ? scan_addr : read_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= scan_addr;
      wr_mask_ff <= mask;
      wr_on_ff   <= on_ff;
   end

   assign wr_data = wr_on_ff ? (rd_data_ff | wr_mask_ff) : (rd_data_ff & ~wr_mask_ff);

   always_ff @(posedge clock) begin
      if (wr_en_ff) mem[wr_addr_ff] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff <= 1'b0;
      end else if (cmd.accept) begin
         reject_ff <= 1'b0;
      end else if (cmd.reject) begin
         reject_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsp_byte_ff <= 8'h00;
      end else if (cmd.rd_capture) begin
         rsp_byte_ff <= rd_data_ff;
      end
   end

   assign rsp_tdata = rsp_byte_ff;
   assign rsp_tuser = reject_ff;

endmodule

// ===== rtl/mono_framebuffer_draw_engine_unit.sv =====
// Throughput: one command at a time, one buffer byte per cycle through the
//   read-modify-write port of the store.
// Reset: synchronous, active high; a clearing pass zeroes the store while
//   req_tready stays low.
`include "mono_framebuffer_draw_engine_unit_macros.svh"

module mono_framebuffer_draw_engine_unit
   import mfde_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   // command word
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] x_first, [15:8] y_first, [23:16] x_second, [31:24] y_second,
   // [32] pixel_on, [35:33] page_sel, [42:36] column_sel, [47:43] zero
   input  logic [47:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   // result word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_byte
   output logic [7:0]  rsp_tdata,
   // [0] status
   output logic [0:0]  rsp_tuser
);

   // controller and datapath talk only through these two bundles
   dp_cmd_type    cmd;
   dp_status_type status;

   mfde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // store, scan cursor, request latch and result registers
   mfde_datapath #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // idle, response and scan never overlap
   `MFDE_ASSERT_IMP(a_phase_excl, 1'b1, ($onehot0({req_tready, rsp_tvalid, cmd.step})), "phase overlap")
   // last scan read is followed by the drain state so the final write lands first
   `MFDE_ASSERT_NXT(a_drain, (cmd.step && status.scan_last), (!cmd.step), "no drain after scan")
   // only a read command returns a nonzero byte
   `MFDE_ASSERT_IMP(a_byte_zero, (rsp_tvalid && status.kind != KIND_READ), (rsp_tdata == 8'h00), "byte on non-read")

endmodule
